// ===== sv/ptm_pkg.sv =====
// Package with the shared request codes and sequencer states of the periodic timer multiplexer.
package ptm_pkg;

   // Request codes carried by req_type.
   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_ELAPSE = 2'd2,
      REQ_NOP    = 2'd3
   } req_code_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ADD,
      ST_DONE
   } seq_state_type;

endpackage

// ===== sv/ptm_mem.sv =====
// Slot memory holding period and remaining time, one write port and one registered read port.
module ptm_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 65
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ptm_elapse.sv =====
// Per-slot elapse arithmetic: subtract with saturation, expiry test and period reload.
module ptm_elapse #(
   parameter int TIME_BITS = 32
) (
   input  logic [TIME_BITS:0]   remaining,
   input  logic [TIME_BITS-1:0] period,
   input  logic [TIME_BITS-1:0] elapsed,
   output logic [TIME_BITS:0]   remaining_next,
   output logic                 fire
);

   localparam int REM_W  = TIME_BITS + 1;
   localparam int DIFF_W = TIME_BITS + 2;

   logic [DIFF_W-1:0] diff;
   logic              below_floor;
   logic [REM_W-1:0]  clamped;

   // Remaining time is signed; the difference gets one guard bit.
   assign diff = {remaining[TIME_BITS], remaining} - {2'b00, elapsed};

   // The result drops below the most negative value when the two top bits disagree.
   assign below_floor = diff[DIFF_W-1] & ~diff[DIFF_W-2];
   assign clamped     = below_floor ? {1'b1, {TIME_BITS{1'b0}}} : diff[REM_W-1:0];

   // A slot at zero or below fires and gets its period back.
   assign fire           = clamped[TIME_BITS] | (clamped == '0);
   assign remaining_next = fire ? (clamped + {1'b0, period}) : clamped;

endmodule

// ===== sv/periodic_timer_multiplexer.sv =====
// Top level of the periodic timer multiplexer: request sequencer, slot scan and result register.
//
//   Channel   Handshake              Payload
//   req       req_valid / req_stall  req_type, req_slot, req_period_ns, req_elapsed_ns
//   rsp       rsp_valid / rsp_stall  rsp_fired_mask, rsp_shortest_ns, rsp_has_shortest,
//                                    rsp_slot_found
//
// One item at a time: a no-op, a miss or a remove without rescan goes from the accept to DONE,
// which loads the result register; an add without rescan passes through ADD first. An elapse,
// and a remove that frees the shortest slot, walk the slot memory one entry a cycle, set by its
// single read port; an add that frees it then passes through ADD. IDLE follows each item.
// Reset is synchronous and clears valid bits, the shortest-period record and all handshakes.
// A stalled result holds in its register; the item behind it finishes and waits for the register.
module periodic_timer_multiplexer #(
   parameter int SLOTS     = 16,
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [3:0]  req_slot,
   input  logic [31:0] req_period_ns,
   input  logic [31:0] req_elapsed_ns,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_fired_mask,
   output logic [31:0] rsp_shortest_ns,
   output logic        rsp_has_shortest,
   output logic        rsp_slot_found
);

   import ptm_pkg::*;

   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = IDX_W + 1;
   localparam int REM_W  = TIME_BITS + 1;
   localparam int WORD_W = TIME_BITS + REM_W;

   // Control and state registers.
   seq_state_type        state_ff, state_in;
   req_code_type         op_ff, op_in;
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic [TIME_BITS-1:0] min_period_ff, min_period_in;
   logic [IDX_W-1:0]     min_slot_ff, min_slot_in;
   logic                 min_valid_ff, min_valid_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Item registers.
   logic [IDX_W-1:0]     slot_ff, slot_in;
   logic [TIME_BITS-1:0] period_ff, period_in;
   logic [TIME_BITS-1:0] elapsed_ff, elapsed_in;
   logic [SLOTS-1:0]     fired_ff, fired_in;
   logic                 found_ff, found_in;

   // Result registers.
   logic [15:0]          fired_mask_ff, fired_mask_in;
   logic [31:0]          shortest_ff, shortest_in;
   logic                 has_shortest_ff, has_shortest_in;
   logic                 slot_found_ff, slot_found_in;

   // Memory port signals.
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   logic [WORD_W-1:0]    mem_wdata;
   logic [IDX_W-1:0]     mem_raddr;
   logic [WORD_W-1:0]    mem_rdata;
   logic [TIME_BITS-1:0] rd_period;
   logic [REM_W-1:0]     rd_rem;
   logic [REM_W-1:0]     new_rem;
   logic                 new_fire;

   // Request decode.
   logic [6:0]           slot_ext;
   logic                 slot_ok;
   logic [IDX_W-1:0]     req_idx;
   logic                 req_hit;
   logic                 min_hit;
   logic [63:0]          period_wide;
   logic [63:0]          elapsed_wide;
   logic [TIME_BITS-1:0] period_t;
   logic [TIME_BITS-1:0] elapsed_t;
   logic [63:0]          fired_wide;
   logic [63:0]          shortest_wide;

   assign slot_ext     = {3'b000, req_slot};
   assign slot_ok      = slot_ext < 7'(SLOTS);
   assign req_idx      = slot_ext[IDX_W-1:0];
   assign req_hit      = slot_ok && valid_ff[req_idx];
   assign min_hit      = req_hit && min_valid_ff && (min_slot_ff == req_idx);
   assign period_wide  = 64'(req_period_ns);
   assign elapsed_wide = 64'(req_elapsed_ns);
   assign period_t     = period_wide[TIME_BITS-1:0];
   assign elapsed_t    = elapsed_wide[TIME_BITS-1:0];
   assign fired_wide   = 64'(fired_ff);
   assign shortest_wide = 64'(min_period_ff);

   assign rd_period = mem_rdata[WORD_W-1:REM_W];
   assign rd_rem    = mem_rdata[REM_W-1:0];

   // Slot memory: period in the upper field, signed remaining time in the lower.
   ptm_mem #(
      .DEPTH  (SLOTS),
      .ADDR_W (IDX_W),
      .DATA_W (WORD_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Elapse arithmetic on the entry read in the previous cycle.
   ptm_elapse #(
      .TIME_BITS (TIME_BITS)
   ) u_elapse (
      .remaining      (rd_rem),
      .period         (rd_period),
      .elapsed        (elapsed_ff),
      .remaining_next (new_rem),
      .fire           (new_fire)
   );

   // Sequencer: next state, memory access and result loading.
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      valid_in        = valid_ff;
      min_period_in   = min_period_ff;
      min_slot_in     = min_slot_ff;
      min_valid_in    = min_valid_ff;
      cnt_in          = cnt_ff;
      rd_vld_in       = 1'b0;
      rd_idx_in       = rd_idx_ff;
      slot_in         = slot_ff;
      period_in       = period_ff;
      elapsed_in      = elapsed_ff;
      fired_in        = fired_ff;
      found_in        = found_ff;
      fired_mask_in   = fired_mask_ff;
      shortest_in     = shortest_ff;
      has_shortest_in = has_shortest_ff;
      slot_found_in   = slot_found_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;
      mem_we          = 1'b0;
      mem_waddr       = rd_idx_ff;
      mem_wdata       = {rd_period, new_rem};
      mem_raddr       = cnt_ff[IDX_W-1:0];
      req_stall       = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in      = req_code_type'(req_type);
               slot_in    = req_idx;
               period_in  = period_t;
               elapsed_in = elapsed_t;
               found_in   = 1'b1;
               fired_in   = '0;
               cnt_in     = '0;
               state_in   = ST_DONE;
               case (op_in)
                  REQ_ADD: begin
                     if (slot_ok) begin
                        // Load the entry now; the slot stays free until any rescan is over.
                        mem_we            = 1'b1;
                        mem_waddr         = req_idx;
                        mem_wdata         = {period_t, 1'b0, period_t};
                        valid_in[req_idx] = 1'b0;
                        if (min_hit) begin
                           min_period_in = '1;
                           min_slot_in   = '0;
                           min_valid_in  = 1'b0;
                           state_in      = ST_SCAN;
                        end else begin
                           state_in = ST_ADD;
                        end
                     end
                  end
                  REQ_REMOVE: begin
                     if (req_hit) begin
                        valid_in[req_idx] = 1'b0;
                        if (min_hit) begin
                           min_period_in = '1;
                           min_slot_in   = '0;
                           min_valid_in  = 1'b0;
                           state_in      = ST_SCAN;
                        end
                     end else begin
                        found_in = 1'b0;
                     end
                  end
                  REQ_ELAPSE: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // Issue one read per cycle.
            if (cnt_ff < CNT_W'(SLOTS)) begin
               rd_vld_in = 1'b1;
               rd_idx_in = cnt_ff[IDX_W-1:0];
               cnt_in    = cnt_ff + 1'b1;
            end
            // Handle the entry read in the previous cycle.
            if (rd_vld_ff && valid_ff[rd_idx_ff]) begin
               if (op_ff == REQ_ELAPSE) begin
                  mem_we              = 1'b1;
                  fired_in[rd_idx_ff] = new_fire;
               end else if (rd_period <= min_period_ff) begin
                  // Minimum search; a tie goes to the later slot.
                  min_period_in = rd_period;
                  min_slot_in   = rd_idx_ff;
                  min_valid_in  = 1'b1;
               end
            end
            if (!rd_vld_ff && (cnt_ff == CNT_W'(SLOTS))) begin
               state_in = (op_ff == REQ_ADD) ? ST_ADD : ST_DONE;
            end
         end

         ST_ADD: begin
            // Occupy the slot and take its period if it is the new shortest.
            valid_in[slot_ff] = 1'b1;
            if (!min_valid_ff || (period_ff < min_period_ff)) begin
               min_period_in = period_ff;
               min_slot_in   = slot_ff;
               min_valid_in  = 1'b1;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               fired_mask_in   = fired_wide[15:0];
               shortest_in     = shortest_wide[31:0];
               has_shortest_in = min_valid_ff;
               slot_found_in   = found_ff;
               state_in        = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= REQ_NOP;
         valid_ff      <= '0;
         min_period_ff <= '1;
         min_slot_ff   <= '0;
         min_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         valid_ff      <= valid_in;
         min_period_ff <= min_period_in;
         min_slot_ff   <= min_slot_in;
         min_valid_ff  <= min_valid_in;
         cnt_ff        <= cnt_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_idx_ff       <= rd_idx_in;
      slot_ff         <= slot_in;
      period_ff       <= period_in;
      elapsed_ff      <= elapsed_in;
      fired_ff        <= fired_in;
      found_ff        <= found_in;
      fired_mask_ff   <= fired_mask_in;
      shortest_ff     <= shortest_in;
      has_shortest_ff <= has_shortest_in;
      slot_found_ff   <= slot_found_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fired_mask   = fired_mask_ff;
   assign rsp_shortest_ns  = shortest_ff;
   assign rsp_has_shortest = has_shortest_ff;
   assign rsp_slot_found   = slot_found_ff;

`ifndef SYNTH
   // Between items the recorded shortest slot is occupied.
   a_min_slot_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && min_valid_ff) |-> valid_ff[min_slot_ff])
      else $error("shortest slot is not occupied");

   // With no shortest held, the shortest period reads as all ones.
   a_min_empty_ones: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !min_valid_ff) |-> (&min_period_ff))
      else $error("empty shortest record is not all ones");

   // Read data is only consumed inside a scan.
   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_SCAN))
      else $error("memory read outstanding outside a scan");

   // An accepted item always starts work.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted item did not leave idle");
`endif

endmodule
